[src/dit_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dit_pkg
// Shared constants and types of the disjoint interval tracker.
// ----------------------------------------------------------------------------
package dit_pkg;

   localparam int MaxIntervalsDefault = 16;
   localparam int ValueBitsDefault    = 16;

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_ADD  = 3'b010,
      ST_READ = 3'b100
   } state_type;

   typedef struct packed {
      logic valid;
      logic gt;
      logic touch;
   } cell_flags_type;

   typedef struct packed {
      logic sample;
      logic apply;
      logic touch_any;
      logic merge_any;
      logic full;
   } cell_ctl_type;

endpackage
`default_nettype wire

[src/disjoint_interval_tracker.sv]
`timescale 1ns / 1ps
`default_nettype none
// Add word: compare in every cell, then shift/merge in the cell row.
// Read word: one result per cycle while the output is not stalled, from a mux
// over the cells; an empty table gives a single word marked empty; one word at a time.
// Reset (synchronous) empties the table and clears the overflow flag.
// ----------------------------------------------------------------------------
// disjoint_interval_tracker
// Sorted set of disjoint intervals kept in a row of compare/shift cells.
// ----------------------------------------------------------------------------
module disjoint_interval_tracker #(
   parameter int MAX_INTERVALS = dit_pkg::MaxIntervalsDefault,
   parameter int VALUE_BITS    = dit_pkg::ValueBitsDefault
) (
   input  wire                   clock,
   input  wire                   reset,
   input  wire                   req_valid,
   output logic                  req_stall,
   input  wire                   req_operation,
   input  wire  [15:0]           req_value,
   output logic                  rsp_valid,
   input  wire                   rsp_stall,
   output logic [15:0]           rsp_interval_start,
   output logic [15:0]           rsp_interval_end,
   output logic                  rsp_last_interval,
   output logic                  rsp_table_empty,
   output logic                  rsp_overflow_seen
);
   import dit_pkg::*;

   localparam int IdxW  = $clog2(MAX_INTERVALS);
   localparam int SlotW = $clog2(MAX_INTERVALS + 1);

   state_type             state_ff, state_in;
   logic [VALUE_BITS-1:0] value_ff, value_in;
   logic [VALUE_BITS-1:0] req_v;
   logic                  ovf_ff, ovf_in;
   logic [IdxW-1:0]       idx_ff, idx_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [15:0]           o_start_ff, o_start_in, o_end_ff, o_end_in;
   logic                  o_last_ff, o_last_in, o_empty_ff, o_empty_in;
   logic                  o_ovf_ff, o_ovf_in;

   cell_ctl_type          ctl;
   cell_flags_type        fl [MAX_INTERVALS+1];
   logic [VALUE_BITS-1:0] st [MAX_INTERVALS+1];
   logic [VALUE_BITS-1:0] en [MAX_INTERVALS+1];
   logic [MAX_INTERVALS:0] valid_vec;
   logic                  touch_any, merge_any;
   logic                  accept, out_free, last_now;
   logic [SlotW-1:0]      idx_x, idx_p1;
   cell_flags_type        head_flags;

   assign req_v    = VALUE_BITS'(req_value);
   assign accept   = req_valid && !req_stall;
   assign req_stall = (state_ff != ST_IDLE);
   assign out_free = !rsp_valid_ff || !rsp_stall;

   assign fl[MAX_INTERVALS] = '{valid: 1'b0, gt: 1'b0, touch: 1'b0};
   assign st[MAX_INTERVALS] = '0;
   assign en[MAX_INTERVALS] = '0;
   assign head_flags = '{valid: 1'b1, gt: 1'b0, touch: 1'b0};

   always_comb begin
      touch_any = 1'b0;
      merge_any = 1'b0;
      for (int i = 0; i < MAX_INTERVALS; i++) begin
         touch_any = touch_any | fl[i].touch;
         merge_any = merge_any | (fl[i].touch & fl[i+1].touch);
      end
      for (int i = 0; i <= MAX_INTERVALS; i++) valid_vec[i] = fl[i].valid;
   end

   assign ctl = '{sample: accept && !req_operation,
                  apply: (state_ff == ST_ADD),
                  touch_any: touch_any,
                  merge_any: merge_any,
                  full: fl[MAX_INTERVALS-1].valid};

   genvar g;
   generate
      for (g = 0; g < MAX_INTERVALS; g++) begin : g_cell
         dit_cell #(.VALUE_BITS(VALUE_BITS)) u_cell (
            .clock        (clock),
            .reset        (reset),
            .ctl          (ctl),
            .sample_value (req_v),
            .apply_value  (value_ff),
            .left_flags   ((g == 0) ? head_flags : fl[(g == 0) ? 0 : g-1]),
            .left_start   (st[(g == 0) ? 0 : g-1]),
            .left_end     (en[(g == 0) ? 0 : g-1]),
            .right_flags  (fl[g+1]),
            .right_start  (st[g+1]),
            .right_end    (en[g+1]),
            .flags        (fl[g]),
            .start        (st[g]),
            .stop         (en[g])
         );
      end
   endgenerate

   assign idx_x    = SlotW'(idx_ff);
   assign idx_p1   = idx_x + SlotW'(1);
   assign last_now = !valid_vec[idx_p1];

   always_comb begin
      state_in     = state_ff;
      value_in     = value_ff;
      ovf_in       = ovf_ff;
      idx_in       = idx_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      o_start_in   = o_start_ff;
      o_end_in     = o_end_ff;
      o_last_in    = o_last_ff;
      o_empty_in   = o_empty_ff;
      o_ovf_in     = o_ovf_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               value_in = req_v;
               idx_in   = '0;
               state_in = req_operation ? ST_READ : ST_ADD;
            end
         end
         ST_ADD: begin
            if (!touch_any && fl[MAX_INTERVALS-1].valid) ovf_in = 1'b1;
            state_in = ST_IDLE;
         end
         ST_READ: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               o_ovf_in     = ovf_ff;
               if (!valid_vec[0]) begin
                  o_start_in = '0;
                  o_end_in   = '0;
                  o_last_in  = 1'b1;
                  o_empty_in = 1'b1;
                  state_in   = ST_IDLE;
               end else begin
                  o_start_in = 16'(st[idx_x]);
                  o_end_in   = 16'(en[idx_x]);
                  o_last_in  = last_now;
                  o_empty_in = 1'b0;
                  idx_in     = idx_p1[IdxW-1:0];
                  if (last_now) state_in = ST_IDLE;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         ovf_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
         idx_ff       <= '0;
      end else begin
         state_ff     <= state_in;
         ovf_ff       <= ovf_in;
         rsp_valid_ff <= rsp_valid_in;
         idx_ff       <= idx_in;
      end
      value_ff   <= value_in;
      o_start_ff <= o_start_in;
      o_end_ff   <= o_end_in;
      o_last_ff  <= o_last_in;
      o_empty_ff <= o_empty_in;
      o_ovf_ff   <= o_ovf_in;
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_interval_start = o_start_ff;
   assign rsp_interval_end   = o_end_ff;
   assign rsp_last_interval  = o_last_ff;
   assign rsp_table_empty    = o_empty_ff;
   assign rsp_overflow_seen  = o_ovf_ff;

endmodule
`default_nettype wire

[src/dit_cell.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dit_cell
// One table slot: holds an interval, compares against a new value and shifts,
// merges or loads in step with its neighbors.
// ----------------------------------------------------------------------------
module dit_cell #(
   parameter int VALUE_BITS = dit_pkg::ValueBitsDefault
) (
   input  wire                         clock,
   input  wire                         reset,
   input  dit_pkg::cell_ctl_type       ctl,
   input  wire  [VALUE_BITS-1:0]       sample_value,
   input  wire  [VALUE_BITS-1:0]       apply_value,
   input  dit_pkg::cell_flags_type     left_flags,
   input  wire  [VALUE_BITS-1:0]       left_start,
   input  wire  [VALUE_BITS-1:0]       left_end,
   input  dit_pkg::cell_flags_type     right_flags,
   input  wire  [VALUE_BITS-1:0]       right_start,
   input  wire  [VALUE_BITS-1:0]       right_end,
   output dit_pkg::cell_flags_type     flags,
   output logic [VALUE_BITS-1:0]       start,
   output logic [VALUE_BITS-1:0]       stop
);
   import dit_pkg::*;

   logic                  valid_ff, valid_in;
   logic                  gt_ff, gt_in;
   logic                  touch_ff, touch_in;
   logic [VALUE_BITS-1:0] start_ff, start_in;
   logic [VALUE_BITS-1:0] end_ff, end_in;
   logic [VALUE_BITS:0]   value_p1;
   logic [VALUE_BITS:0]   end_p1;
   logic                  is_pos;
   logic                  take_left;

   always_comb begin
      value_p1 = {1'b0, sample_value} + {{VALUE_BITS{1'b0}}, 1'b1};
      end_p1   = {1'b0, end_ff} + {{VALUE_BITS{1'b0}}, 1'b1};
      gt_in    = gt_ff;
      touch_in = touch_ff;
      if (ctl.sample) begin
         gt_in    = valid_ff && (start_ff > sample_value);
         touch_in = valid_ff && ({1'b0, start_ff} <= value_p1)
                    && (end_p1 >= {1'b0, sample_value});
      end
   end

   assign is_pos    = (gt_ff || !valid_ff) && left_flags.valid && !left_flags.gt;
   assign take_left = gt_ff || (!valid_ff && left_flags.gt);

   always_comb begin
      valid_in = valid_ff;
      start_in = start_ff;
      end_in   = end_ff;
      if (ctl.apply) begin
         if (!ctl.touch_any) begin
            if (!ctl.full) begin
               if (is_pos) begin
                  start_in = apply_value;
                  end_in   = apply_value;
                  valid_in = 1'b1;
               end else if (take_left) begin
                  start_in = left_start;
                  end_in   = left_end;
                  valid_in = 1'b1;
               end
            end
         end else if (ctl.merge_any) begin
            if (touch_ff && right_flags.touch) begin
               end_in = right_end;
            end else if (gt_ff) begin
               start_in = right_start;
               end_in   = right_end;
               valid_in = right_flags.valid;
            end
         end else if (touch_ff) begin
            if (apply_value < start_ff) start_in = apply_value;
            if (apply_value > end_ff) end_in = apply_value;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         gt_ff    <= 1'b0;
         touch_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         gt_ff    <= gt_in;
         touch_ff <= touch_in;
      end
      start_ff <= start_in;
      end_ff   <= end_in;
   end

   assign flags = '{valid: valid_ff, gt: gt_ff, touch: touch_ff};
   assign start = start_ff;
   assign stop  = end_ff;

endmodule
`default_nettype wire

[bench/tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Drives add and read words into the interval tracker and checks every
// streamed interval against an in-bench model of the sorted interval set.
// ----------------------------------------------------------------------------

localparam bit OP_ADD  = 1'b0;
localparam bit OP_READ = 1'b1;

typedef struct {
   logic [15:0] istart;
   logic [15:0] iend;
   logic        last;
   logic        empty;
   logic        ovf;
} span_word_t;

class span_scoreboard;
   logic [15:0] lo_tab [16];
   logic [15:0] hi_tab [16];
   int          count;
   bit          ovf;
   span_word_t  pending [$];
   int          errors;
   int          checked;
   int          overflows;

   function void clear();
      count = 0; ovf = 0; pending.delete(); errors = 0; checked = 0; overflows = 0;
   endfunction

   function void insert_value(logic [15:0] v);
      int pos, lo, hi, removed, i, n;
      logic [16:0] ns, ne;
      n = count; pos = 0; ns = v; ne = v;
      while (pos < n && lo_tab[pos] <= v) pos++;
      lo = pos;
      if (pos > 0 && {1'b0, hi_tab[pos-1]} + 17'd1 >= {1'b0, v}) begin
         lo = pos - 1;
         ns = lo_tab[lo];
         if (hi_tab[lo] > ne) ne = hi_tab[lo];
      end
      hi = pos;
      while (hi < n && {1'b0, lo_tab[hi]} <= ne + 17'd1) begin
         if (hi_tab[hi] > ne) ne = hi_tab[hi];
         hi++;
      end
      removed = hi - lo;
      if (removed == 0) begin
         if (n >= 16) begin
            ovf = 1; overflows++;
            return;
         end
         for (i = n; i > lo; i--) begin
            lo_tab[i] = lo_tab[i-1]; hi_tab[i] = hi_tab[i-1];
         end
         n++;
      end else begin
         for (i = hi; i < n; i++) begin
            lo_tab[i-removed+1] = lo_tab[i]; hi_tab[i-removed+1] = hi_tab[i];
         end
         n = n - removed + 1;
      end
      lo_tab[lo] = ns[15:0];
      hi_tab[lo] = ne[15:0];
      count = n;
   endfunction

   function void note_word(bit op, logic [15:0] v);
      span_word_t w;
      if (op == OP_ADD) begin
         insert_value(v);
         return;
      end
      if (count == 0) begin
         w.istart = 0; w.iend = 0; w.last = 1; w.empty = 1; w.ovf = ovf;
         pending = {pending, w};
         return;
      end
      for (int k = 0; k < count; k++) begin
         w.istart = lo_tab[k]; w.iend = hi_tab[k]; w.last = (k == count - 1);
         w.empty = 0; w.ovf = ovf;
         pending = {pending, w};
      end
   endfunction

   function void check_word(span_word_t got);
      span_word_t exp;
      checked++;
      if (pending.size() == 0) begin
         errors++;
         if (errors <= 10) $display("unexpected result word start=%0d end=%0d",
                                    got.istart, got.iend);
         return;
      end
      exp = pending.pop_front();
      if (got.istart !== exp.istart || got.iend !== exp.iend || got.last !== exp.last ||
          got.empty !== exp.empty || got.ovf !== exp.ovf) begin
         errors++;
         if (errors <= 10)
            $display("mismatch exp s=%0d e=%0d l=%0b m=%0b o=%0b got s=%0d e=%0d l=%0b m=%0b o=%0b",
                     exp.istart, exp.iend, exp.last, exp.empty, exp.ovf,
                     got.istart, got.iend, got.last, got.empty, got.ovf);
      end
   endfunction
endclass

module tb;
   logic        clock = 0;
   logic        reset = 1;
   logic        req_valid = 0;
   logic        req_stall;
   logic        req_operation = 0;
   logic [15:0] req_value = 0;
   logic        rsp_valid;
   logic        rsp_stall = 0;
   logic [15:0] rsp_interval_start, rsp_interval_end;
   logic        rsp_last_interval, rsp_table_empty, rsp_overflow_seen;

   span_scoreboard board;
   int  send_idle_pct = 0;
   int  stall_pct = 0;
   int  idle_cycles = 0;
   int  words_sent = 0;
   int  reads_sent = 0;

   localparam int WatchdogLimit = 20000;

   always #1 clock = ~clock;

   disjoint_interval_tracker u_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall),
      .req_operation(req_operation), .req_value(req_value),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_interval_start(rsp_interval_start), .rsp_interval_end(rsp_interval_end),
      .rsp_last_interval(rsp_last_interval), .rsp_table_empty(rsp_table_empty),
      .rsp_overflow_seen(rsp_overflow_seen)
   );

   always @(posedge clock) begin
      span_word_t w;
      if (!reset) begin
         if (req_valid && !req_stall) begin
            board.note_word(req_operation, req_value);
            idle_cycles <= 0;
         end else if (rsp_valid && !rsp_stall) begin
            idle_cycles <= 0;
         end else begin
            idle_cycles <= idle_cycles + 1;
         end
         if (rsp_valid && !rsp_stall) begin
            w.istart = rsp_interval_start; w.iend = rsp_interval_end;
            w.last = rsp_last_interval; w.empty = rsp_table_empty;
            w.ovf = rsp_overflow_seen;
            board.check_word(w);
         end
         if (idle_cycles >= WatchdogLimit) begin
            $display("watchdog expired");
            $display("disjoint_interval_tracker verification failed");
            $finish;
         end
      end
   end

   always @(negedge clock)
      rsp_stall <= ($urandom_range(99) < stall_pct);

   task automatic send_word(bit op, logic [15:0] v);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 0;
         @(negedge clock);
      end
      req_valid <= 1;
      req_operation <= op;
      req_value <= v;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      @(negedge clock);
      words_sent++;
      if (op == OP_READ) reads_sent++;
   endtask

   task automatic random_phase(int n, int base, int spread);
      for (int i = 0; i < n; i++) begin
         if ($urandom_range(9) == 0) send_word(OP_READ, 16'($urandom));
         else if ($urandom_range(9) == 0) send_word(OP_ADD, 16'($urandom));
         else send_word(OP_ADD, 16'(base + $urandom_range(spread)));
      end
      send_word(OP_READ, 16'($urandom));
   endtask

   initial begin
      board = new();
      board.clear();
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 0;
      // directed: empty read, edges, merges, duplicates
      send_word(OP_READ, 16'hFFFF);
      send_word(OP_ADD, 16'd0);
      send_word(OP_ADD, 16'hFFFF);
      send_word(OP_ADD, 16'd2);
      send_word(OP_READ, 16'd0);
      send_word(OP_ADD, 16'd1);
      send_word(OP_ADD, 16'd1);
      send_word(OP_ADD, 16'hFFFD);
      send_word(OP_ADD, 16'hFFFE);
      send_word(OP_ADD, 16'h5555);
      send_word(OP_ADD, 16'hAAAA);
      send_word(OP_READ, 16'h0);
      for (int k = 0; k < 16; k++) send_word(OP_ADD, 16'(100 + 3 * k));
      send_word(OP_READ, 16'h0);
      send_word(OP_ADD, 16'd101);
      send_word(OP_READ, 16'h0);
      send_idle_pct = 0;  stall_pct = 0;  random_phase(82, 200, 60);
      send_idle_pct = 62; stall_pct = 0;  random_phase(82, 40000, 50);
      send_idle_pct = 0;  stall_pct = 62; random_phase(82, 1000, 40);
      send_idle_pct = 21; stall_pct = 21; random_phase(82, 65500, 35);
      req_valid <= 0;
      stall_pct = 0;
      while (board.pending.size() != 0 && idle_cycles < WatchdogLimit) @(posedge clock);
      repeat (40) @(posedge clock);
      $display("sent %0d words (%0d reads), checked %0d interval words, %0d dropped adds",
               words_sent, reads_sent, board.checked, board.overflows);
      if (board.errors == 0 && board.pending.size() == 0) begin
         $display("disjoint_interval_tracker verification clean");
      end else begin
         $display("%0d mismatches, %0d words outstanding", board.errors,
                  board.pending.size());
         $display("disjoint_interval_tracker verification failed");
      end
      $finish;
   end
endmodule

[disjoint_interval_tracker.f]
src/dit_pkg.sv
src/dit_cell.sv
src/disjoint_interval_tracker.sv
bench/tb.sv
